@@ rtl/stok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types and constants of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int LINE_BITS     = 16;
  localparam int POSITION_BITS = 24;
  localparam int LENGTH_BITS   = 16;
  localparam int KIND_BITS     = 5;
  localparam int WIN_BITS      = 40;
  localparam int MAX_RECS      = 3;

  localparam int DATA_BITS = 8 + KIND_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS;
  localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

  localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = '1;

  localparam logic [KIND_BITS-1:0] K_NUMBER  = 5'd0;
  localparam logic [KIND_BITS-1:0] K_STRING  = 5'd1;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd2;
  localparam logic [KIND_BITS-1:0] K_CONST   = 5'd3;
  localparam logic [KIND_BITS-1:0] K_DEF     = 5'd4;
  localparam logic [KIND_BITS-1:0] K_FUNC    = 5'd5;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd6;
  localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd8;
  localparam logic [KIND_BITS-1:0] K_STAR    = 5'd10;
  localparam logic [KIND_BITS-1:0] K_EXP     = 5'd12;
  localparam logic [KIND_BITS-1:0] K_EXPEQ   = 5'd13;
  localparam logic [KIND_BITS-1:0] K_SLASH   = 5'd14;
  localparam logic [KIND_BITS-1:0] K_PERCENT = 5'd16;
  localparam logic [KIND_BITS-1:0] K_ASSIGN  = 5'd18;
  localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd20;
  localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd21;
  localparam logic [KIND_BITS-1:0] K_SEMI    = 5'd22;
  localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd23;
  localparam logic [KIND_BITS-1:0] K_LBRACK  = 5'd24;
  localparam logic [KIND_BITS-1:0] K_RBRACK  = 5'd25;
  localparam logic [KIND_BITS-1:0] K_LBRACE  = 5'd26;
  localparam logic [KIND_BITS-1:0] K_RBRACE  = 5'd27;
  localparam logic [KIND_BITS-1:0] K_INVALID = 5'd28;
  localparam logic [KIND_BITS-1:0] K_EOF     = 5'd29;

  localparam logic [WIN_BITS-1:0] WORD_CONST = 40'h636F6E7374;
  localparam logic [23:0]         WORD_DEF   = 24'h646566;
  localparam logic [31:0]         WORD_FUNC  = 32'h66756E63;

  localparam logic REC_BYTE = 1'b0;
  localparam logic REC_TOKEN = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               lex;
    logic [KIND_BITS-1:0]     tok;
    logic [LINE_BITS-1:0]     line;
    logic [POSITION_BITS-1:0] pos;
    logic [LENGTH_BITS-1:0]   len;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t [MAX_RECS-1:0] recs;
  } batch_t;

endpackage

@@ rtl/stok_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_core
// Scan state registers and the single-pass next-state and record logic.
// ----------------------------------------------------------------------------
module stok_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      in_byte,
  input  logic            eoi,
  output stok_pkg::batch_t batch,
  output logic            fin,
  output logic            line_zero
);
  import stok_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_INT, M_FRAC, M_STR, M_IDENT, M_OP, M_EXP
  } mode_t;

  mode_t                    mode_r, mode_nxt;
  logic                     quote_r, quote_nxt;
  logic [7:0]               pend_r, pend_nxt;
  logic [WIN_BITS-1:0]      win_r, win_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] tstart_r, tstart_nxt;
  logic [LINE_BITS-1:0]     tline_r, tline_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  logic                     fin_r, fin_nxt;

  function automatic logic [KIND_BITS-1:0] op_kind(input logic [7:0] p);
    case (p)
      "+":     op_kind = K_PLUS;
      "-":     op_kind = K_MINUS;
      "*":     op_kind = K_STAR;
      "/":     op_kind = K_SLASH;
      "%":     op_kind = K_PERCENT;
      default: op_kind = K_ASSIGN;
    endcase
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    is_num = (b >= 8'd48) && (b <= 8'd57);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
  endfunction

  always_comb begin
    logic [1:0]           n;
    rec_t [MAX_RECS-1:0]  recs;
    logic                 fresh;
    logic [KIND_BITS-1:0] ck;
    logic                 close;
    logic [KIND_BITS-1:0] ik;
    mode_nxt   = mode_r;
    quote_nxt  = quote_r;
    pend_nxt   = pend_r;
    win_nxt    = win_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    len_nxt    = len_r;
    fin_nxt    = fin_r;
    n     = 2'd0;
    recs  = '0;
    fresh = 1'b0;
    close = 1'b0;
    ck    = K_INVALID;
    ik    = K_IDENT;
    if ((len_r == LENGTH_BITS'(5)) && (win_r == WORD_CONST)) ik = K_CONST;
    else if ((len_r == LENGTH_BITS'(3)) && (win_r[23:0] == WORD_DEF)) ik = K_DEF;
    else if ((len_r == LENGTH_BITS'(4)) && (win_r[31:0] == WORD_FUNC)) ik = K_FUNC;

    if (fin_r) begin
      recs[0] = '{REC_TOKEN, 8'd0, K_EOF, line_r, pos_r, '0};
      n = 2'd1;
    end else if (eoi) begin
      case (mode_r)
        M_INT, M_FRAC: begin close = 1'b1; ck = K_NUMBER; end
        M_STR:         begin close = 1'b1; ck = K_INVALID; end
        M_IDENT:       begin close = 1'b1; ck = ik; end
        M_OP:          begin close = 1'b1; ck = op_kind(pend_r); end
        M_EXP:         begin close = 1'b1; ck = K_EXP; end
        default:       close = 1'b0;
      endcase
      if (close) begin
        recs[0] = '{REC_TOKEN, 8'd0, ck, tline_r, tstart_r, len_r};
        n = 2'd1;
        pend_nxt = 8'd0;
      end
      mode_nxt = M_IDLE;
      recs[n] = '{REC_TOKEN, 8'd0, K_EOF, line_r, pos_r, '0};
      n = n + 2'd1;
      fin_nxt = 1'b1;
    end else begin
      case (mode_r)
        M_INT: begin
          if (is_num(in_byte)) begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
          end else if (in_byte == ".") begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
            mode_nxt = M_FRAC;
          end else begin
            close = 1'b1; ck = K_NUMBER; fresh = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_num(in_byte)) begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
          end else begin
            close = 1'b1; ck = K_NUMBER; fresh = 1'b1;
          end
        end
        M_STR: begin
          if (in_byte == (quote_r ? 8'h22 : 8'h27)) begin
            close = 1'b1; ck = K_STRING;
          end else begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter(in_byte) || is_num(in_byte)) begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
            win_nxt = {win_r[WIN_BITS-9:0], in_byte};
          end else begin
            close = 1'b1; ck = ik; fresh = 1'b1;
          end
        end
        M_OP: begin
          if (in_byte == "=") begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
            close = 1'b1; ck = op_kind(pend_r) + 1'b1;
          end else if ((pend_r == "*") && (in_byte == "*")) begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
            mode_nxt = M_EXP;
          end else begin
            close = 1'b1; ck = op_kind(pend_r); fresh = 1'b1;
          end
        end
        M_EXP: begin
          if (in_byte == "=") begin
            recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
            if (len_nxt < LEN_MAX) len_nxt = len_nxt + 1'b1;
            close = 1'b1; ck = K_EXPEQ;
          end else begin
            close = 1'b1; ck = K_EXP; fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (close) begin
        recs[n] = '{REC_TOKEN, 8'd0, ck, tline_nxt, tstart_nxt, len_nxt};
        n = n + 2'd1;
        mode_nxt = M_IDLE;
        pend_nxt = 8'd0;
        close = 1'b0;
      end
      if (fresh) begin
        if ((in_byte == " ") || (in_byte == 8'h09) || (in_byte == 8'h0A)) begin
          if ((in_byte == 8'h0A) && (line_nxt < LINE_MAX)) line_nxt = line_nxt + 1'b1;
          mode_nxt = M_IDLE;
        end else begin
          tstart_nxt = pos_r;
          tline_nxt  = line_nxt;
          len_nxt    = '0;
          if ((in_byte == "'") || (in_byte == 8'h22)) begin
            quote_nxt = (in_byte == 8'h22);
            mode_nxt  = M_STR;
          end else begin
            if (in_byte == ".") begin
              mode_nxt = M_FRAC;
            end else if (is_num(in_byte)) begin
              mode_nxt = M_INT;
            end else if (is_letter(in_byte)) begin
              win_nxt  = WIN_BITS'(in_byte);
              mode_nxt = M_IDENT;
            end else if ((in_byte == "+") || (in_byte == "-") || (in_byte == "*") ||
                         (in_byte == "/") || (in_byte == "%") || (in_byte == "=")) begin
              pend_nxt = in_byte;
              mode_nxt = M_OP;
            end else begin
              close = 1'b1;
              case (in_byte)
                "(":     ck = K_LPAREN;
                ")":     ck = K_RPAREN;
                ";":     ck = K_SEMI;
                ",":     ck = K_COMMA;
                "[":     ck = K_LBRACK;
                "]":     ck = K_RBRACK;
                "{":     ck = K_LBRACE;
                "}":     ck = K_RBRACE;
                default: ck = K_INVALID;
              endcase
            end
            if (!close || (ck != K_INVALID) || (in_byte == "<") || (in_byte == ">")) begin
              recs[n] = '{REC_BYTE, in_byte, '0, '0, '0, '0}; n = n + 2'd1;
              len_nxt = LENGTH_BITS'(1);
            end
            if (close) begin
              recs[n] = '{REC_TOKEN, 8'd0, ck, tline_nxt, tstart_nxt, len_nxt};
              n = n + 2'd1;
              mode_nxt = M_IDLE;
              pend_nxt = 8'd0;
            end
          end
        end
      end
      if (pos_r < POS_MAX) pos_nxt = pos_r + 1'b1;
    end
    batch.n    = n;
    batch.recs = recs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      quote_r  <= 1'b0;
      pend_r   <= 8'd0;
      win_r    <= '0;
      line_r   <= LINE_BITS'(1);
      pos_r    <= '0;
      tstart_r <= '0;
      tline_r  <= LINE_BITS'(1);
      len_r    <= '0;
      fin_r    <= 1'b0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      quote_r  <= quote_nxt;
      pend_r   <= pend_nxt;
      win_r    <= win_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      len_r    <= len_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign fin       = fin_r;
  assign line_zero = (line_r == '0);

endmodule

@@ rtl/stok_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_outq
// Result register: holds up to three records of one item, drains one a beat.
// ----------------------------------------------------------------------------
module stok_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  stok_pkg::batch_t batch,
  output logic            can_load,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic            out_tlast,
  output stok_pkg::rec_t  head,
  output logic [1:0]      level
);
  import stok_pkg::*;

  rec_t [MAX_RECS-1:0] q_r;
  logic [1:0]          cnt_r;
  logic                pop;

  assign pop        = out_tvalid && out_tready;
  assign can_load   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = (cnt_r == 2'd1);
  assign head       = q_r[0];
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= batch.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= batch.recs;
    end else if (pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

endmodule

@@ rtl/source_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte or end mark in, byte and token records out.
//
// Input beat: in_tdata[7:0] is the source byte, in_tlast marks end of input.
// Output beat: out_tuser is 0 for a lexeme byte record, 1 for a token record;
// out_tdata carries byte, kind, line, position and length; out_tlast marks
// the final record caused by one input beat. An input beat causes zero to
// three records. Records of a beat appear in the cycle after it is taken.
// While the receiver is ready, records drain one per cycle and a beat with
// one or no record is taken every cycle; a beat with more records holds the
// input until its last record drains. The rate is set by the three-entry
// result register, which takes a new batch only when it empties. When the
// receiver stalls the head record holds, and the input stalls until the
// result register is empty or its last record drains in the same cycle.
// Reset clears the scan state to idle, line one, position zero, and empties
// the result register. After end of input every beat yields one eof record.
// ----------------------------------------------------------------------------
module source_tokenizer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // in_byte
  input  logic                            in_tlast,   // end_of_input
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // lexeme_byte, token_kind, token_line, token_position, token_length, zero fill
  output logic [stok_pkg::TDATA_BITS-1:0] out_tdata,
  output logic                            out_tuser,  // record_kind
  output logic                            out_tlast   // last
);
  import stok_pkg::*;

  batch_t     batch;
  rec_t       head;
  logic       acc;
  logic       can_load;
  logic       fin;
  logic       line_zero;
  logic [1:0] level;

  assign in_tready = can_load;
  assign acc       = in_tvalid && in_tready;

  stok_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_byte   (in_tdata),
    .eoi       (in_tlast),
    .batch     (batch),
    .fin       (fin),
    .line_zero (line_zero)
  );

  stok_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (acc),
    .batch      (batch),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .head       (head),
    .level      (level)
  );

  assign out_tuser = head.kind;
  assign out_tdata = TDATA_BITS'({head.len, head.pos, head.line, head.tok, head.lex});

  a_no_take_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (level > 2'd1) |-> !in_tready) else $error("input taken over pending records");
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> fin) else $error("finished flag dropped");
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !line_zero) else $error("line count reached zero");
  a_fin_one_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && $past(fin) && fin) |=> (level == 2'd1)) else $error("eof batch size");

endmodule

@@ dv/source_tokenizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_test
// Self-checking bench for the source tokenizer: a directed stimulus table and
// then random source text. Each beat goes through a lexer model that queues
// the expected records, and every output beat is checked against them, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module source_tokenizer_test;
  import stok_pkg::*;

  localparam int M_IDLE = 0, M_INT = 1, M_FRAC = 2, M_STR = 3, M_IDENT = 4, M_OP = 5,
                 M_EXP = 6;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [7:0]           ch;
    logic                 eoi;
    logic                 fixed;
    logic [KIND_BITS-1:0] tok;
  } stim_t;

  typedef struct packed {
    rec_t r;
    logic lst;
  } exp_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_BITS-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  exp_rec_t pending_recs[$];
  stim_t directed[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_rx = 1'b0;
  bit quiet_rx = 1'b0;

  // lexer state
  int lx_mode;
  logic lx_dq;
  logic [7:0] lx_op;
  logic [WIN_BITS-1:0] lx_win;
  logic [LINE_BITS-1:0] lx_line, lx_tline;
  logic [POSITION_BITS-1:0] lx_pos, lx_tpos;
  logic [LENGTH_BITS-1:0] lx_len;
  logic lx_done;
  exp_rec_t beat_recs[$];

  source_tokenizer u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit letter_ch(logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic bit digit_ch(logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

  function automatic logic [KIND_BITS-1:0] op_kind(logic [7:0] p);
    case (p)
      "+": return K_PLUS;
      "-": return K_MINUS;
      "*": return K_STAR;
      "/": return K_SLASH;
      "%": return K_PERCENT;
      default: return K_ASSIGN;
    endcase
  endfunction

  function automatic int sep_code(logic [7:0] b);
    case (b)
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      ";": return K_SEMI;
      ",": return K_COMMA;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      default: return -1;
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind();
    if (lx_len == 5 && lx_win == WORD_CONST) return K_CONST;
    if (lx_len == 3 && lx_win[23:0] == WORD_DEF) return K_DEF;
    if (lx_len == 4 && lx_win[31:0] == WORD_FUNC) return K_FUNC;
    return K_IDENT;
  endfunction

  task automatic push_rec(logic kind, logic [7:0] b, logic [KIND_BITS-1:0] tk,
                          logic [LINE_BITS-1:0] ln, logic [POSITION_BITS-1:0] ps,
                          logic [LENGTH_BITS-1:0] ln2);
    exp_rec_t e;
    e.r.kind = kind;
    e.r.lex = b;
    e.r.tok = tk;
    e.r.line = ln;
    e.r.pos = ps;
    e.r.len = ln2;
    e.lst = 1'b0;
    if (beat_recs.size() < MAX_RECS) beat_recs.push_back(e);
  endtask

  task automatic lex_byte(logic [7:0] b);
    push_rec(REC_BYTE, b, '0, '0, '0, '0);
    if (lx_len != LEN_MAX) lx_len++;
  endtask

  task automatic close_tok(logic [KIND_BITS-1:0] k);
    push_rec(REC_TOKEN, 8'd0, k, lx_tline, lx_tpos, lx_len);
    lx_mode = M_IDLE;
    lx_op = '0;
  endtask

  task automatic lex_fresh(logic [7:0] b);
    int s;
    if (b == " " || b == 8'd9 || b == 8'd10) begin
      if (b == 8'd10 && lx_line != LINE_MAX) lx_line++;
      return;
    end
    lx_tpos = lx_pos;
    lx_tline = lx_line;
    lx_len = '0;
    s = sep_code(b);
    if (b == ".") begin
      lex_byte(b); lx_mode = M_FRAC;
    end else if (digit_ch(b)) begin
      lex_byte(b); lx_mode = M_INT;
    end else if (b == "'" || b == "\"") begin
      lx_dq = (b == "\""); lx_mode = M_STR;
    end else if (letter_ch(b)) begin
      lex_byte(b); lx_win = WIN_BITS'(b); lx_mode = M_IDENT;
    end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "%" || b == "=") begin
      lex_byte(b); lx_op = b; lx_mode = M_OP;
    end else if (b == "<" || b == ">") begin
      lex_byte(b); close_tok(K_INVALID);
    end else if (s >= 0) begin
      lex_byte(b); close_tok(KIND_BITS'(s));
    end else begin
      close_tok(K_INVALID);
    end
  endtask

  task automatic lex_beat(logic [7:0] b, logic eoi);
    beat_recs.delete();
    if (lx_done) begin
      push_rec(REC_TOKEN, 8'd0, K_EOF, lx_line, lx_pos, '0);
    end else if (eoi) begin
      case (lx_mode)
        M_INT, M_FRAC: close_tok(K_NUMBER);
        M_STR: close_tok(K_INVALID);
        M_IDENT: close_tok(word_kind());
        M_OP: close_tok(op_kind(lx_op));
        M_EXP: close_tok(K_EXP);
        default: lx_mode = M_IDLE;
      endcase
      push_rec(REC_TOKEN, 8'd0, K_EOF, lx_line, lx_pos, '0);
      lx_done = 1'b1;
    end else begin
      case (lx_mode)
        M_INT:
          if (digit_ch(b)) lex_byte(b);
          else if (b == ".") begin
            lex_byte(b); lx_mode = M_FRAC;
          end else begin
            close_tok(K_NUMBER); lex_fresh(b);
          end
        M_FRAC:
          if (digit_ch(b)) lex_byte(b);
          else begin
            close_tok(K_NUMBER); lex_fresh(b);
          end
        M_STR:
          if (b == (lx_dq ? 8'd34 : 8'd39)) close_tok(K_STRING);
          else lex_byte(b);
        M_IDENT:
          if (letter_ch(b) || digit_ch(b)) begin
            lex_byte(b); lx_win = {lx_win[WIN_BITS-9:0], b};
          end else begin
            close_tok(word_kind()); lex_fresh(b);
          end
        M_OP:
          if (b == "=") begin
            lex_byte(b); close_tok(op_kind(lx_op) + 1'b1);
          end else if (lx_op == "*" && b == "*") begin
            lex_byte(b); lx_mode = M_EXP;
          end else begin
            close_tok(op_kind(lx_op)); lex_fresh(b);
          end
        M_EXP:
          if (b == "=") begin
            lex_byte(b); close_tok(K_EXPEQ);
          end else begin
            close_tok(K_EXP); lex_fresh(b);
          end
        default: begin
          lx_mode = M_IDLE; lex_fresh(b);
        end
      endcase
      if (lx_pos != POS_MAX) lx_pos++;
    end
    if (beat_recs.size() > 0) beat_recs[beat_recs.size()-1].lst = 1'b1;
    foreach (beat_recs[i]) pending_recs.push_back(beat_recs[i]);
  endtask

  task automatic lex_reset();
    lx_mode = M_IDLE;
    lx_dq = 1'b0;
    lx_op = '0;
    lx_win = '0;
    lx_line = LINE_BITS'(1);
    lx_pos = '0;
    lx_tpos = '0;
    lx_tline = LINE_BITS'(1);
    lx_len = '0;
    lx_done = 1'b0;
  endtask

  task automatic idle_gap(bit fast);
    int n;
    n = fast ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) :
                    $urandom_range(0, 2));
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // drive one beat; predict at acceptance
  task automatic send(logic [7:0] b, logic eoi, bit fast, logic fixed,
                      logic [KIND_BITS-1:0] tok);
    in_tdata <= b;
    in_tlast <= eoi;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_beat(b, eoi);
    if (fixed) begin
      // the closing record of this beat must carry the typed-in kind
      if (pending_recs[pending_recs.size()-1].r.tok != tok) begin
        $error("token_kind table: expected %0d, predicted %0d", tok,
               pending_recs[pending_recs.size()-1].r.tok);
        errors++;
      end
    end
    @(negedge clk);
    idle_gap(fast);
  endtask

  task automatic add_row(logic [7:0] b, logic eoi, logic fixed, logic [KIND_BITS-1:0] tok);
    stim_t s;
    s.ch = b;
    s.eoi = eoi;
    s.fixed = fixed;
    s.tok = tok;
    directed.push_back(s);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_char(int cls);
    string ops = "+-*/%=";
    string seps = "()[]{};,<>";
    case (cls)
      0: return 8'd48 + 8'($urandom_range(0, 9));
      1: return $urandom_range(0, 1) ? 8'd97 + 8'($urandom_range(0, 25)) :
                8'd65 + 8'($urandom_range(0, 25));
      2: return ops[$urandom_range(0, 5)];
      3: return seps[$urandom_range(0, 9)];
      4: return $urandom_range(0, 2) == 0 ? 8'd10 : ($urandom_range(0, 1) ? 8'd32 : 8'd9);
      5: return $urandom_range(0, 1) ? "'" : "\"";
      6: return ".";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    automatic string words[6] = '{"const", "def", "func", "defx", "x9", "3.14"};
    automatic string w;
    lex_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    add_row("+", 1'b0, 1'b0, '0);
    add_row("=", 1'b0, 1'b1, K_PLUS + 1'b1);
    add_row("*", 1'b0, 1'b0, '0);
    add_row("*", 1'b0, 1'b0, '0);
    add_row("=", 1'b0, 1'b1, K_EXPEQ);
    add_row("<", 1'b0, 1'b1, K_INVALID);
    add_row(8'd0, 1'b0, 1'b1, K_INVALID);
    add_row(8'd255, 1'b0, 1'b1, K_INVALID);
    add_row("(", 1'b0, 1'b1, K_LPAREN);
    add_row("}", 1'b0, 1'b1, K_RBRACE);
    add_row(8'd10, 1'b0, 1'b0, '0);
    add_row(".", 1'b0, 1'b0, '0);
    add_row("5", 1'b0, 1'b0, '0);
    add_row(";", 1'b0, 1'b0, '0);
    add_row("c", 1'b0, 1'b0, '0);
    add_row("o", 1'b0, 1'b0, '0);
    add_row("n", 1'b0, 1'b0, '0);
    add_row("s", 1'b0, 1'b0, '0);
    add_row("t", 1'b0, 1'b0, '0);
    add_row(" ", 1'b0, 1'b1, K_CONST);
    add_row("%", 1'b0, 1'b0, '0);
    add_row("/", 1'b0, 1'b0, '0);
    add_row("'", 1'b0, 1'b0, '0);
    add_row(8'd10, 1'b0, 1'b0, '0);
    add_row("\"", 1'b0, 1'b0, '0);
    foreach (directed[i])
      send(directed[i].ch, directed[i].eoi, i < 10, directed[i].fixed, directed[i].tok);

    // sender pause until all records are back
    wait_drained();

    // long receiver hold while the sender keeps offering
    hold_rx = 1'b1;
    foreach (words[i]) begin
      w = words[i];
      for (int k = 0; k < w.len(); k++) send(w[k], 1'b0, 1'b1, 1'b0, '0);
      send(" ", 1'b0, 1'b1, 1'b0, '0);
    end

    // random text: mostly well-formed tokens
    for (int t = 0; t < 28; t++) begin
      automatic int kind = $urandom_range(0, 9);
      automatic int n = $urandom_range(1, 4);
      automatic logic [7:0] q;
      case (kind)
        0, 1: for (int k = 0; k < n; k++) send(rand_char(k == 0 ? 1 : $urandom_range(0, 1)),
                                                1'b0, 1'b0, 1'b0, '0);
        2: begin
          for (int k = 0; k < n; k++) send(rand_char(0), 1'b0, 1'b0, 1'b0, '0);
          if ($urandom_range(0, 1)) send(".", 1'b0, 1'b0, 1'b0, '0);
          send(rand_char(0), 1'b0, 1'b0, 1'b0, '0);
        end
        3: begin
          q = rand_char(5);
          send(q, 1'b0, 1'b0, 1'b0, '0);
          for (int k = 0; k < n; k++) send(rand_char($urandom_range(0, 7)), 1'b0, 1'b0,
                                           1'b0, '0);
          send(q, 1'b0, 1'b0, 1'b0, '0);
        end
        4, 5: begin
          send(rand_char(2), 1'b0, 1'b0, 1'b0, '0);
          if ($urandom_range(0, 1)) send($urandom_range(0, 1) ? "=" : "*", 1'b0, 1'b0, 1'b0, '0);
        end
        6: send(rand_char(3), 1'b0, 1'b0, 1'b0, '0);
        7: send(rand_char(4), 1'b0, 1'b0, 1'b0, '0);
        default: send(rand_char($urandom_range(0, 7)), 1'b0, 1'b0, 1'b0, '0);
      endcase
      if ($urandom_range(0, 2) == 0) send(" ", 1'b0, 1'b0, 1'b0, '0);
    end

    send(8'd0, 1'b1, 1'b0, 1'b1, K_EOF);
    send(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1, K_EOF);
    send(8'd0, 1'b1, 1'b0, 1'b1, K_EOF);
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver idling and the long hold
  always @(negedge clk) begin
    if (hold_rx && !quiet_rx) begin
      quiet_rx = 1'b1;
      out_tready <= 1'b0;
      repeat (60) @(negedge clk);
      hold_rx = 1'b0;
      quiet_rx = 1'b0;
    end else if (!quiet_rx) begin
      if ($urandom_range(0, 29) == 0) out_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_tready <= $urandom_range(0, 1);
      else out_tready <= 1'b1;
    end
  end

  // check each output beat against the oldest expected record
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rec_t got;
      exp_rec_t e;
      got = rec_t'({out_tuser, out_tdata[DATA_BITS-1:0]});
      got.kind = out_tuser;
      got.lex = out_tdata[7:0];
      got.tok = out_tdata[8 +: KIND_BITS];
      got.line = out_tdata[8 + KIND_BITS +: LINE_BITS];
      got.pos = out_tdata[8 + KIND_BITS + LINE_BITS +: POSITION_BITS];
      got.len = out_tdata[8 + KIND_BITS + LINE_BITS + POSITION_BITS +: LENGTH_BITS];
      if (pending_recs.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        e = pending_recs.pop_front();
        if (got.kind != e.r.kind) begin
          $error("record_kind: expected %0d, got %0d", e.r.kind, got.kind); errors++;
        end
        if (got.lex != e.r.lex) begin
          $error("lexeme_byte: expected %0d, got %0d", e.r.lex, got.lex); errors++;
        end
        if (got.tok != e.r.tok) begin
          $error("token_kind: expected %0d, got %0d", e.r.tok, got.tok); errors++;
        end
        if (got.line != e.r.line) begin
          $error("token_line: expected %0d, got %0d", e.r.line, got.line); errors++;
        end
        if (got.pos != e.r.pos) begin
          $error("token_position: expected %0d, got %0d", e.r.pos, got.pos); errors++;
        end
        if (got.len != e.r.len) begin
          $error("token_length: expected %0d, got %0d", e.r.len, got.len); errors++;
        end
        if (out_tlast != e.lst) begin
          $error("last: expected %0d, got %0d", e.lst, out_tlast); errors++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_recs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ source_tokenizer.f @@
rtl/stok_pkg.sv
rtl/stok_core.sv
rtl/stok_outq.sv
rtl/source_tokenizer.sv
dv/source_tokenizer_test.sv
